### sv/gcpm_pkg.sv
package gcpm_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 20;
  localparam int CordicSteps = 16;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = IdxBits + 1;
  localparam int PointBits = 2 * CoordBits;
  localparam int DiffBits = CoordBits + 1;
  localparam int SqBits = 2 * DiffBits;
  localparam int DistBits = SqBits + 1;
  localparam int AccBits = 24;
  localparam int CvBits = DiffBits + 3;
  localparam int StepBits = $clog2(CordicSteps + 1);
  localparam logic signed [AccBits-1:0] HalfPiQ20 = AccBits'(1647099);

  localparam logic CmdLeft = 1'b0;
  localparam logic CmdRight = 1'b1;

  typedef struct packed {
    logic signed [DiffBits-1:0] dx;
    logic signed [DiffBits-1:0] dz;
  } vec_t;

  function automatic logic signed [AccBits-1:0] atan_q20(input logic [4:0] i);
    logic signed [AccBits-1:0] r;
    case (i)
      5'd0: r = AccBits'(823550);
      5'd1: r = AccBits'(486170);
      5'd2: r = AccBits'(256879);
      5'd3: r = AccBits'(130396);
      5'd4: r = AccBits'(65451);
      5'd5: r = AccBits'(32757);
      5'd6: r = AccBits'(16383);
      5'd7: r = AccBits'(8192);
      5'd8: r = AccBits'(4096);
      5'd9: r = AccBits'(2048);
      5'd10: r = AccBits'(1024);
      5'd11: r = AccBits'(512);
      5'd12: r = AccBits'(256);
      5'd13: r = AccBits'(128);
      5'd14: r = AccBits'(64);
      5'd15: r = AccBits'(32);
      5'd16: r = AccBits'(16);
      5'd17: r = AccBits'(8);
      5'd18: r = AccBits'(4);
      5'd19: r = AccBits'(2);
      5'd20: r = AccBits'(1);
      5'd21: r = AccBits'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/gcpm_ram.sv
module gcpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### sv/gcpm_cordic.sv
module gcpm_cordic import gcpm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  vec_t                vin,
  output logic                done,
  output logic signed [15:0]  angle
);

  logic signed [CvBits-1:0] x, y;
  logic signed [AccBits-1:0] acc;
  logic [StepBits-1:0] step;
  logic running;
  logic signed [AccBits-1:0] rnd;

  assign rnd = acc + AccBits'(64);

  // pre-rotate into the right half plane, then one micro-rotation a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        step <= '0;
        running <= 1'b1;
        if (vin.dx < 0 && vin.dz >= 0) begin
          x <= CvBits'(vin.dz);
          y <= -CvBits'(vin.dx);
          acc <= HalfPiQ20;
        end else if (vin.dx < 0) begin
          x <= -CvBits'(vin.dz);
          y <= CvBits'(vin.dx);
          acc <= -HalfPiQ20;
        end else begin
          x <= CvBits'(vin.dx);
          y <= CvBits'(vin.dz);
          acc <= '0;
        end
        if (vin.dx == 0 && vin.dz == 0) begin
          x <= '0;
          y <= '0;
          acc <= AccBits'(-64);
        end
      end else if (running) begin
        if (y > 0) begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          acc <= acc + atan_q20(5'(step));
        end else if (y < 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          acc <= acc - atan_q20(5'(step));
        end
        if (step == StepBits'(CordicSteps - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign angle = 16'(rnd >>> 7);

endmodule

### sv/greedy_cone_pair_midpoints_core.sv
// Channel | Ports                                        | Handshake
// input   | command, x_pos, z_pos, last                  | start & !busy
// result  | mid_x, mid_z, heading, none_found,           | strobe, one cycle
//         | overflowed, last_result                      |
// Points load one per cycle. After a last item, each left point scans the
// right store one entry a cycle, then a matched pair is fetched and marked,
// its heading is found by CORDIC, and the pair is held to be emitted; a run is
// bounded by the serial scan over the right memory port. busy is high for the
// whole run.
// Reset clears counts and flags; each right point carries its taken bit, which
// is cleared as the point loads. The point memories are not cleared.
// The receiver cannot stall.
module greedy_cone_pair_midpoints_core import gcpm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic signed [CoordBits-1:0] x_pos,
  input  logic signed [CoordBits-1:0] z_pos,
  input  logic                        last,
  output logic                        strobe,
  output logic signed [CoordBits-1:0] mid_x,
  output logic signed [CoordBits-1:0] mid_z,
  output logic signed [15:0]          heading,
  output logic                        none_found,
  output logic                        overflowed,
  output logic                        last_result
);

  localparam logic [2:0] SLoad = 3'd0;
  localparam logic [2:0] SLeft = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SPick = 3'd3;
  localparam logic [2:0] SCord = 3'd4;
  localparam logic [2:0] SEmit = 3'd5;

  logic [2:0] state;
  logic [CntBits-1:0] left_count, right_count;
  logic drop_flag;
  logic [CntBits-1:0] li, ri;
  logic [IdxBits-1:0] rd_idx, best;
  logic have, rvalid, any_out;
  logic [DistBits-1:0] best_d;
  logic signed [CoordBits-1:0] lx, lz, bx, bz;
  logic signed [CoordBits-1:0] hold_x, hold_z;
  logic signed [15:0] hold_hd;
  logic [PointBits-1:0] l_rdata;
  logic [PointBits:0] r_rdata, r_wdata;
  logic l_we, r_we, r_mark, r_wen, acc;
  logic [IdxBits-1:0] l_raddr, r_raddr, r_waddr;
  logic signed [DiffBits-1:0] ddx, ddz;
  logic [SqBits-1:0] sqx, sqz;
  logic [DistBits-1:0] sq_dist;
  logic cgo, cdone;
  logic signed [15:0] cang;
  vec_t cvec;
  logic signed [CoordBits-1:0] rx, rz;

  assign acc = start && !busy;
  assign busy = (state != SLoad);
  assign l_we = acc && command == CmdLeft && left_count < CntBits'(MaxPoints);
  assign r_we = acc && command == CmdRight && right_count < CntBits'(MaxPoints);
  assign l_raddr = li[IdxBits-1:0];
  assign r_raddr = (state == SPick) ? best : ri[IdxBits-1:0];

  // load a right point with its taken bit clear, or mark the picked one
  assign r_mark = (state == SPick) && rvalid;
  assign r_wen = r_we || r_mark;
  assign r_waddr = r_mark ? best : right_count[IdxBits-1:0];
  assign r_wdata = r_mark ? {1'b1, r_rdata[PointBits-1:0]} : {1'b0, x_pos, z_pos};

  gcpm_ram #(.Width(PointBits), .Depth(MaxPoints)) u_left (
    .clk(clk), .we(l_we), .waddr(left_count[IdxBits-1:0]),
    .wdata({x_pos, z_pos}), .raddr(l_raddr), .rdata(l_rdata));
  gcpm_ram #(.Width(PointBits + 1), .Depth(MaxPoints)) u_right (
    .clk(clk), .we(r_wen), .waddr(r_waddr),
    .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));

  assign rx = r_rdata[PointBits-1:CoordBits];
  assign rz = r_rdata[CoordBits-1:0];
  assign ddx = DiffBits'(rx) - DiffBits'(lx);
  assign ddz = DiffBits'(rz) - DiffBits'(lz);
  assign sqx = SqBits'(ddx * ddx);
  assign sqz = SqBits'(ddz * ddz);
  assign sq_dist = DistBits'(sqx) + DistBits'(sqz);

  assign cvec.dx = DiffBits'(bx) - DiffBits'(lx);
  assign cvec.dz = DiffBits'(bz) - DiffBits'(lz);

  gcpm_cordic u_cordic (
    .clk(clk), .rst(rst), .go(cgo), .vin(cvec), .done(cdone), .angle(cang));

  // load, scan, pick, angle, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SLoad;
      left_count <= '0;
      right_count <= '0;
      drop_flag <= 1'b0;
      strobe <= 1'b0;
      cgo <= 1'b0;
      any_out <= 1'b0;
    end else begin
      strobe <= 1'b0;
      cgo <= 1'b0;
      case (state)
        SLoad: begin
          if (acc) begin
            if (l_we) left_count <= left_count + 1'b1;
            if (r_we) right_count <= right_count + 1'b1;
            if (!l_we && !r_we) drop_flag <= 1'b1;
            if (last) begin
              if ((left_count == '0 && !l_we) || (right_count == '0 && !r_we)) begin
                strobe <= 1'b1;
                mid_x <= '0;
                mid_z <= '0;
                heading <= '0;
                none_found <= 1'b1;
                overflowed <= drop_flag || (!l_we && !r_we);
                last_result <= 1'b1;
                left_count <= '0;
                right_count <= '0;
                drop_flag <= 1'b0;
              end else begin
                li <= '0;
                any_out <= 1'b0;
                state <= SLeft;
              end
            end
          end
        end
        SLeft: begin
          // left point address li is presented here; l_rdata holds that point in SScan
          if (li == left_count) begin
            // run over: emit the held pair, if any, as the final result
            state <= SLoad;
            left_count <= '0;
            right_count <= '0;
            drop_flag <= 1'b0;
            if (any_out) begin
              strobe <= 1'b1;
              mid_x <= hold_x;
              mid_z <= hold_z;
              heading <= hold_hd;
              none_found <= 1'b0;
              overflowed <= drop_flag;
              last_result <= 1'b1;
            end
          end else begin
            ri <= '0;
            have <= 1'b0;
            rvalid <= 1'b0;
            state <= SScan;
          end
        end
        SScan: begin
          if (ri == '0 && !rvalid) begin
            lx <= l_rdata[PointBits-1:CoordBits];
            lz <= l_rdata[CoordBits-1:0];
          end
          rvalid <= (ri < right_count);
          rd_idx <= ri[IdxBits-1:0];
          if (rvalid && !r_rdata[PointBits] && (!have || sq_dist < best_d)) begin
            have <= 1'b1;
            best <= rd_idx;
            best_d <= sq_dist;
          end
          if (ri < right_count) ri <= ri + 1'b1;
          else if (!rvalid || ri == right_count) begin
            if (rvalid) begin
              // fold the final entry then leave
              rvalid <= 1'b0;
              ri <= right_count + 1'b1;
            end else begin
              li <= li + 1'b1;
              if (have) state <= SPick;
              else state <= SLeft;
            end
          end
        end
        SPick: begin
          // best entry read lands next cycle, then its taken bit is written back
          if (!cgo && !rvalid) begin
            rvalid <= 1'b1;
          end else if (rvalid) begin
            bx <= rx;
            bz <= rz;
            rvalid <= 1'b0;
            cgo <= 1'b1;
            state <= SCord;
          end
        end
        SCord: begin
          if (cdone) state <= SEmit;
        end
        SEmit: begin
          // emit the held pair, if any, and hold this one until the next is known
          if (any_out) begin
            strobe <= 1'b1;
            mid_x <= hold_x;
            mid_z <= hold_z;
            heading <= hold_hd;
            none_found <= 1'b0;
            overflowed <= drop_flag;
            last_result <= 1'b0;
          end
          hold_x <= CoordBits'((DiffBits'(lx) + DiffBits'(bx)) >>> 1);
          hold_z <= CoordBits'((DiffBits'(lz) + DiffBits'(bz)) >>> 1);
          hold_hd <= cang;
          any_out <= 1'b1;
          state <= SLeft;
        end
        default: state <= SLoad;
      endcase
    end
  end

endmodule
